FILE: rtl/lge_pkg.sv
package lge_pkg;

    // Grid geometry
    localparam int ROWS   = 32;
    localparam int COLS   = 64;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int IDX_W   = 5;
    localparam int CELLS_W = 64;
    localparam int GEN_W   = 32;

    // Item kinds
    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE   = 2'd0,
        FUNC_ADVANCE = 2'd1,
        FUNC_READ    = 2'd2
    } t_func;

    // Controls shared by every row cell
    typedef struct packed {
        logic shift;
        logic commit;
    } t_cell_ctl;

endpackage

FILE: rtl/lge_cell.sv
module lge_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lge_pkg::t_cell_ctl        i_ctl,
    input  logic                      i_wr_en,
    input  logic [lge_pkg::COLS-1:0]  i_wr_data,
    input  logic [lge_pkg::COLS-1:0]  i_g_nbr,
    input  logic [lge_pkg::COLS-1:0]  i_nx_nbr,
    output logic [lge_pkg::COLS-1:0]  o_g,
    output logic [lge_pkg::COLS-1:0]  o_nx
);

    logic [lge_pkg::COLS-1:0] r_g;
    logic [lge_pkg::COLS-1:0] r_nx;

    // Current row: load on write, pass along the ring while sweeping, take new row on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g <= '0;
        end else if (i_wr_en) begin
            r_g <= i_wr_data;
        end else if (i_ctl.shift) begin
            r_g <= i_g_nbr;
        end else if (i_ctl.commit) begin
            r_g <= r_nx;
        end
    end

    // Next-generation row travels beside the current one
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_nx <= i_nx_nbr;
        end
    end

    assign o_g  = r_g;
    assign o_nx = r_nx;

endmodule

FILE: rtl/lge_rule.sv
module lge_rule (
    input  logic [lge_pkg::COLS-1:0] i_up,
    input  logic [lge_pkg::COLS-1:0] i_mid,
    input  logic [lge_pkg::COLS-1:0] i_dn,
    output logic [lge_pkg::COLS-1:0] o_next
);

    // Count the eight wrapped neighbors of each column and apply the birth/survive rule
    always_comb begin
        int       lf;
        int       rt;
        logic [3:0] n;
        for (int c = 0; c < lge_pkg::COLS; c++) begin
            lf = (c == 0) ? lge_pkg::COLS - 1 : c - 1;
            rt = (c == lge_pkg::COLS - 1) ? 0 : c + 1;
            n  = 4'(i_up[lf]) + 4'(i_up[c]) + 4'(i_up[rt])
               + 4'(i_mid[lf]) + 4'(i_mid[rt])
               + 4'(i_dn[lf]) + 4'(i_dn[c]) + 4'(i_dn[rt]);
            o_next[c] = (n == 4'd3) || ((n == 4'd2) && i_mid[c]);
        end
    end

endmodule

FILE: rtl/life_generation_engine_top.sv
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_ready     i_func, i_row_index, i_row_cells
// out       output     o_out_valid / i_out_ready   o_row_out, o_stable, o_generation
//
// Write, read and unused codes need no sweep; their result is registered when the item is accepted.
// An advance sweeps first: the row ring rotates once past the rule unit,
// one row per cycle, then the commit state commits the new grid or sets the stable flag.
// Reset (synchronous, active low) clears the grid, the generation count and the flag.
// A new item is taken while idle and the result register is empty or being drained;
// a stalled result holds its register and blocks only the next item.
module life_generation_engine_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [lge_pkg::FUNC_W-1:0]       i_func,
    input  logic [lge_pkg::IDX_W-1:0]        i_row_index,
    input  logic [lge_pkg::CELLS_W-1:0]      i_row_cells,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [lge_pkg::CELLS_W-1:0]      o_row_out,
    output logic                             o_stable,
    output logic [lge_pkg::GEN_W-1:0]        o_generation
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SWEEP  = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    logic [lge_pkg::ROW_AW-1:0]    r_step;
    logic                          r_diff;
    logic [lge_pkg::GEN_W-1:0]     r_gen;
    logic                          r_stable;
    logic                          r_out_valid;
    logic [lge_pkg::CELLS_W-1:0]   r_row_out;

    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_idx_ok;
    logic [lge_pkg::ROW_AW-1:0]    w_sel;
    lge_pkg::t_func                w_func;
    lge_pkg::t_cell_ctl            w_ctl;
    logic [lge_pkg::COLS-1:0]      w_g  [lge_pkg::ROWS];
    logic [lge_pkg::COLS-1:0]      w_nx [lge_pkg::ROWS];
    logic [lge_pkg::COLS-1:0]      w_next;
    logic [lge_pkg::COLS-1:0]      w_wr_data;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_func     = lge_pkg::t_func'(i_func);
    assign w_idx_ok   = 32'(i_row_index) < lge_pkg::ROWS;
    assign w_sel      = lge_pkg::ROW_AW'(i_row_index);
    assign w_wr_data  = i_row_cells[lge_pkg::COLS-1:0];

    assign w_ctl.shift  = (r_state == S_SWEEP);
    assign w_ctl.commit = (r_state == S_COMMIT) && r_diff;

    // Ring of row cells; cell k hands its rows to cell k-1, the head feeds the tail its current row
    for (genvar k = 0; k < lge_pkg::ROWS; k++) begin : g_row
        localparam int NB = (k == lge_pkg::ROWS - 1) ? 0 : k + 1;
        logic w_wr_en;
        logic [lge_pkg::COLS-1:0] w_nx_in;

        assign w_wr_en = w_accept && (w_func == lge_pkg::FUNC_WRITE)
                      && (32'(i_row_index) == k);
        assign w_nx_in = (k == lge_pkg::ROWS - 1) ? w_next : w_nx[NB];

        lge_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_wr_en   (w_wr_en),
            .i_wr_data (w_wr_data),
            .i_g_nbr   (w_g[NB]),
            .i_nx_nbr  (w_nx_in),
            .o_g       (w_g[k]),
            .o_nx      (w_nx[k])
        );
    end

    // Rule unit sees the head row with its wrapped upper and lower neighbors
    lge_rule u_rule (
        .i_up   (w_g[lge_pkg::ROWS-1]),
        .i_mid  (w_g[0]),
        .i_dn   (w_g[1]),
        .o_next (w_next)
    );

    // Sequence the sweep and the commit
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (w_func == lge_pkg::FUNC_ADVANCE)) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (r_step == lge_pkg::ROW_AW'(lge_pkg::ROWS - 1)) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_diff  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SWEEP) begin
                r_step <= r_step + 1'b1;
                if (w_next != w_g[0]) begin
                    r_diff <= 1'b1;
                end
            end else begin
                r_step <= '0;
                r_diff <= 1'b0;
            end
        end
    end

    // Update the generation count and the stable flag at commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen    <= '0;
            r_stable <= 1'b0;
        end else if (r_state == S_COMMIT) begin
            if (r_diff) begin
                r_gen    <= r_gen + 1'b1;
                r_stable <= 1'b0;
            end else begin
                r_stable <= 1'b1;
            end
        end
    end

    // Result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && (w_func != lge_pkg::FUNC_ADVANCE)) begin
            r_out_valid <= 1'b1;
        end else if (r_state == S_COMMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row_out <= '0;
            if ((w_func == lge_pkg::FUNC_READ) && w_idx_ok) begin
                r_row_out <= lge_pkg::CELLS_W'(w_g[w_sel]);
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_row_out    = r_row_out;
    assign o_stable     = r_stable;
    assign o_generation = r_gen;

    // Commit only follows a full sweep
    a_commit_after_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> $past(r_state == S_SWEEP)
            && ($past(r_step) == lge_pkg::ROW_AW'(lge_pkg::ROWS - 1)))
        else $error("commit without a full sweep");

    // No result beat appears mid-sweep
    a_no_beat_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> !$rose(r_out_valid))
        else $error("result beat raised during sweep");

    // Generation count moves only at commit
    a_gen_at_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gen != $past(r_gen)) |-> $past(r_state == S_COMMIT) && $past(r_diff))
        else $error("generation changed outside commit");

    // Commit always lands in an empty result register
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> !r_out_valid)
        else $error("commit while a result beat is pending");

endmodule

FILE: dv/life_generation_engine_top_tb.sv
`timescale 1ns / 100ps

module life_generation_engine_top_tb;

    // Unused item code: must leave the grid alone and return a zero row
    localparam logic [lge_pkg::FUNC_W-1:0] FUNC_UNUSED  = 2'd3;
    localparam logic [lge_pkg::COLS-1:0]   COL_MASK     = {lge_pkg::COLS{1'b1}};
    localparam int                         DRAIN_CYCLES = 2 * lge_pkg::ROWS + 16;
    localparam int                         RANDOM_ITEMS = 1100;

    typedef struct {
        logic [lge_pkg::CELLS_W-1:0] row_out;
        logic                        stable;
        logic [lge_pkg::GEN_W-1:0]   gen_count;
    } t_life_result;

    // Grid predictor plus the queue of results still owed by the block
    class life_grid_scoreboard;
        logic [lge_pkg::COLS-1:0]  grid [lge_pkg::ROWS];
        logic [lge_pkg::GEN_W-1:0] gen_count;
        logic                      stable;
        t_life_result              awaited_results [$];
        int                        mismatches;

        function new();
            for (int r = 0; r < lge_pkg::ROWS; r++) grid[r] = '0;
            gen_count  = '0;
            stable     = 1'b0;
            mismatches = 0;
        endfunction

        // Apply the rule to every cell at once; keep the grid if nothing moves
        function void step_generation();
            logic [lge_pkg::COLS-1:0] fresh [lge_pkg::ROWS];
            bit                       same;
            int                       up, dn, lf, rt, n;
            same = 1'b1;
            for (int r = 0; r < lge_pkg::ROWS; r++) begin
                up = (r + lge_pkg::ROWS - 1) % lge_pkg::ROWS;
                dn = (r + 1) % lge_pkg::ROWS;
                fresh[r] = '0;
                for (int c = 0; c < lge_pkg::COLS; c++) begin
                    lf = (c + lge_pkg::COLS - 1) % lge_pkg::COLS;
                    rt = (c + 1) % lge_pkg::COLS;
                    n  = int'(grid[up][lf]) + int'(grid[up][c]) + int'(grid[up][rt])
                       + int'(grid[r][lf]) + int'(grid[r][rt])
                       + int'(grid[dn][lf]) + int'(grid[dn][c]) + int'(grid[dn][rt]);
                    if (n == 3 || (n == 2 && grid[r][c])) fresh[r][c] = 1'b1;
                end
                if (fresh[r] != grid[r]) same = 1'b0;
            end
            if (same) begin
                stable = 1'b1;
            end else begin
                for (int r = 0; r < lge_pkg::ROWS; r++) grid[r] = fresh[r];
                stable    = 1'b0;
                gen_count = gen_count + 1'b1;
            end
        endfunction

        // Note an accepted input beat and queue the result it owes
        function void note_input(logic [lge_pkg::FUNC_W-1:0] func,
                                 logic [lge_pkg::IDX_W-1:0] idx,
                                 logic [lge_pkg::CELLS_W-1:0] cells);
            t_life_result res;
            res.row_out = '0;
            case (func)
                lge_pkg::FUNC_WRITE: begin
                    if (idx < lge_pkg::ROWS)
                        grid[idx] = cells[lge_pkg::COLS-1:0] & COL_MASK;
                end
                lge_pkg::FUNC_ADVANCE: begin
                    step_generation();
                end
                lge_pkg::FUNC_READ: begin
                    if (idx < lge_pkg::ROWS)
                        res.row_out = lge_pkg::CELLS_W'(grid[idx] & COL_MASK);
                end
                default: begin
                end
            endcase
            res.stable    = stable;
            res.gen_count = gen_count;
            awaited_results.push_back(res);
        endfunction

        task report_mismatch(string what, logic [lge_pkg::CELLS_W-1:0] got,
                             logic [lge_pkg::CELLS_W-1:0] want);
            $display("MISMATCH %s: got %h expected %h", what, got, want);
            mismatches++;
        endtask

        // Compare an output beat field by field with the oldest expectation
        task check_result(logic [lge_pkg::CELLS_W-1:0] row_out, logic stable_out,
                          logic [lge_pkg::GEN_W-1:0] gen_out);
            t_life_result want;
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result", row_out, '0);
                return;
            end
            want = awaited_results.pop_front();
            if (row_out !== want.row_out)
                report_mismatch("row_out", row_out, want.row_out);
            if (stable_out !== want.stable)
                report_mismatch("stable", lge_pkg::CELLS_W'(stable_out),
                                lge_pkg::CELLS_W'(want.stable));
            if (gen_out !== want.gen_count)
                report_mismatch("generation", lge_pkg::CELLS_W'(gen_out),
                                lge_pkg::CELLS_W'(want.gen_count));
        endtask

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_in_valid  = 1'b0;
    logic                        o_in_ready;
    logic [lge_pkg::FUNC_W-1:0]  i_func      = lge_pkg::FUNC_WRITE;
    logic [lge_pkg::IDX_W-1:0]   i_row_index = '0;
    logic [lge_pkg::CELLS_W-1:0] i_row_cells = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic [lge_pkg::CELLS_W-1:0] o_row_out;
    logic                        o_stable;
    logic [lge_pkg::GEN_W-1:0]   o_generation;

    life_grid_scoreboard sb = new();
    bit                  no_idle = 1'b0;
    int                  items_sent = 0;

    life_generation_engine_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_row_index (i_row_index),
        .i_row_cells (i_row_cells),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_row_out   (o_row_out),
        .o_stable    (o_stable),
        .o_generation(o_generation)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Watch both channels at every edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_input(i_func, i_row_index, i_row_cells);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_row_out, o_stable, o_generation);
        end
    end

    // Send one beat after a random gap; hold valid high across back-to-back beats
    task automatic send_item(input logic [lge_pkg::FUNC_W-1:0] func,
                             input logic [lge_pkg::IDX_W-1:0] idx,
                             input logic [lge_pkg::CELLS_W-1:0] cells);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= func;
        i_row_index <= idx;
        i_row_cells <= cells;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Hold off new beats until every owed result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [lge_pkg::CELLS_W-1:0] draw_row_cells();
        logic [lge_pkg::CELLS_W-1:0] a, b, c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return a & b & c;
            4:       return a & b;
            5:       return a | b;
            default: return a;
        endcase
    endfunction

    function automatic logic [lge_pkg::COLS-1:0] rotate_cols(logic [lge_pkg::COLS-1:0] v,
                                                              int sh);
        sh = sh % lge_pkg::COLS;
        if (sh == 0) return v;
        return (v << sh) | (v >> (lge_pkg::COLS - sh));
    endfunction

    task automatic random_single();
        logic [lge_pkg::FUNC_W-1:0] func;
        int                         pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)       func = FUNC_UNUSED;
        else if (pick < 40) func = lge_pkg::FUNC_WRITE;
        else if (pick < 70) func = lge_pkg::FUNC_READ;
        else                func = lge_pkg::FUNC_ADVANCE;
        send_item(func, lge_pkg::IDX_W'($urandom_range(0, lge_pkg::ROWS - 1)),
                  draw_row_cells());
    endtask

    // Run a few generations, reading rows back between them
    task automatic evolve_and_read();
        int steps;
        steps = $urandom_range(1, 8);
        for (int s = 0; s < steps; s++) begin
            send_item(lge_pkg::FUNC_ADVANCE, lge_pkg::IDX_W'($urandom),
                      {$urandom, $urandom});
            repeat ($urandom_range(0, 3))
                send_item(lge_pkg::FUNC_READ,
                          lge_pkg::IDX_W'($urandom_range(0, lge_pkg::ROWS - 1)), '0);
        end
    endtask

    // Fill the whole grid with rows of random density, then evolve it
    task automatic seed_random_grid();
        for (int r = 0; r < lge_pkg::ROWS; r++)
            send_item(lge_pkg::FUNC_WRITE, lge_pkg::IDX_W'(r), draw_row_cells());
        evolve_and_read();
    endtask

    // Clear the grid, drop a glider somewhere (wrapping), then evolve it
    task automatic seed_glider();
        int row0, col0;
        row0 = $urandom_range(0, lge_pkg::ROWS - 1);
        col0 = $urandom_range(0, lge_pkg::COLS - 1);
        for (int r = 0; r < lge_pkg::ROWS; r++)
            send_item(lge_pkg::FUNC_WRITE, lge_pkg::IDX_W'(r), '0);
        send_item(lge_pkg::FUNC_WRITE, lge_pkg::IDX_W'(row0 % lge_pkg::ROWS),
                  lge_pkg::CELLS_W'(rotate_cols(lge_pkg::COLS'(3'b010), col0)));
        send_item(lge_pkg::FUNC_WRITE, lge_pkg::IDX_W'((row0 + 1) % lge_pkg::ROWS),
                  lge_pkg::CELLS_W'(rotate_cols(lge_pkg::COLS'(3'b100), col0)));
        send_item(lge_pkg::FUNC_WRITE, lge_pkg::IDX_W'((row0 + 2) % lge_pkg::ROWS),
                  lge_pkg::CELLS_W'(rotate_cols(lge_pkg::COLS'(3'b111), col0)));
        evolve_and_read();
        evolve_and_read();
    endtask

    // Result side: stall a random number of cycles before each beat
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Stimulus and end of run
    initial begin
        bit drained_mid;
        drained_mid = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset state, empty grid, edge wrap, unused code, still life
        send_item(lge_pkg::FUNC_READ, 5'd5, '0);
        send_item(lge_pkg::FUNC_ADVANCE, 5'd0, '0);
        send_item(lge_pkg::FUNC_WRITE, 5'd31, '1);
        send_item(lge_pkg::FUNC_READ, 5'd31, '0);
        send_item(lge_pkg::FUNC_WRITE, 5'd0, 64'h8000_0000_0000_0003);
        send_item(lge_pkg::FUNC_WRITE, 5'd31, '0);
        send_item(lge_pkg::FUNC_ADVANCE, 5'd31, '1);
        send_item(lge_pkg::FUNC_READ, 5'd31, '1);
        send_item(lge_pkg::FUNC_READ, 5'd0, '0);
        send_item(lge_pkg::FUNC_READ, 5'd1, '0);
        send_item(lge_pkg::FUNC_ADVANCE, 5'd0, '0);
        send_item(FUNC_UNUSED, 5'd31, '1);
        send_item(lge_pkg::FUNC_READ, 5'd0, '0);
        send_item(lge_pkg::FUNC_WRITE, 5'd0, '0);
        send_item(lge_pkg::FUNC_WRITE, 5'd31, 64'h8000_0000_0000_0001);
        send_item(lge_pkg::FUNC_WRITE, 5'd0, 64'h8000_0000_0000_0001);
        send_item(lge_pkg::FUNC_ADVANCE, 5'd0, '0);
        send_item(lge_pkg::FUNC_READ, 5'd31, '0);
        send_item(lge_pkg::FUNC_ADVANCE, 5'd0, '0);
        send_item(lge_pkg::FUNC_WRITE, 5'd30, '1);
        send_item(lge_pkg::FUNC_ADVANCE, 5'd0, '0);
        send_item(lge_pkg::FUNC_ADVANCE, 5'd0, '0);
        send_item(lge_pkg::FUNC_READ, 5'd30, '0);
        send_item(lge_pkg::FUNC_READ, 5'd0, '0);
        wait_drained();

        // Random: mostly seeded grids that evolve, plus single-beat noise
        while (items_sent < RANDOM_ITEMS + 25) begin
            if ($urandom_range(0, 9) == 0) no_idle = ~no_idle;
            if (!drained_mid && items_sent > 600) begin
                drained_mid = 1'b1;
                wait_drained();
            end
            case ($urandom_range(0, 9))
                0, 1, 2: seed_random_grid();
                3:       seed_glider();
                4, 5:    evolve_and_read();
                default: repeat (8) random_single();
            endcase
        end

        i_in_valid <= 1'b0;
        no_idle = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: life_generation_engine_top.f
rtl/lge_pkg.sv
rtl/lge_cell.sv
rtl/lge_rule.sv
rtl/life_generation_engine_top.sv
dv/life_generation_engine_top_tb.sv
